>>> hdl/top_k_frequency_tracker_assert.svh
// Assertion macros shared by the tracker modules.
// Both macros expect a signal named clk, and TKFT_ASSERT also rst_n, in the calling module.
`ifndef TOP_K_FREQUENCY_TRACKER_ASSERT_SVH
`define TOP_K_FREQUENCY_TRACKER_ASSERT_SVH

`ifndef SYNTH
// Checked on every rising edge outside reset.
`define TKFT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tracker assertion failed");
// Checked on every rising edge, reset included.
`define TKFT_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tracker assertion failed");
`else
`define TKFT_ASSERT(lbl, prop)
`define TKFT_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> hdl/tkft_pkg.sv
package tkft_pkg;

    // Number of entries held, and the stored width of a key.
    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 32;

    // Port field widths.
    localparam int KEY_W   = 32;
    localparam int FREQ_W  = 31;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;

    // Derived widths.
    localparam int SLOT_BITS  = $clog2(CAPACITY);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int CMP_BITS   = (COUNT_BITS > SLOT_W) ? COUNT_BITS : SLOT_W;
    localparam int KEY_KEEP   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

    // Command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // Input word.
    typedef struct packed {
        logic              cmd;
        logic [KEY_W-1:0]  key;
        logic [FREQ_W-1:0] freq;
        logic [SLOT_W-1:0] slot;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic               accepted;
        logic               duplicate;
        logic               read_valid;
        logic [KEY_W-1:0]   read_key;
        logic [FREQ_W-1:0]  read_freq;
        logic [COUNT_W-1:0] entry_count;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic compare;
        logic commit;
    } ctrl_cmd_t;

    // Fits a port key into the stored key width.
    function automatic logic [KEY_BITS-1:0] key_fit(input logic [KEY_W-1:0] k);
        return KEY_BITS'(k[KEY_KEEP-1:0]);
    endfunction

endpackage

>>> hdl/top_k_frequency_tracker.sv
// Channel   Ports                 Handshake
// -------   -------------------   ---------------------------------------------
// command   start, item, busy     word taken at a rising edge with start && !busy
// result    done, result          word shown for one cycle while done is high
//
// Each word is handled in order: capture, a parallel compare of every held
// entry, then the priority pick and one-slot shift of the entry registers.
// done rises in the cycle after the shift, and busy is already low then, so a
// new word may be started in the same cycle its predecessor's result shows.
// Reset empties the list at once; no clearing pass is needed.
// The receiver cannot stall, so results are never held back.
module top_k_frequency_tracker
    import tkft_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_word_t  item,
    output logic      busy,
    output logic      done,
    output out_word_t result
);

    ctrl_cmd_t cmd;

    // Sequencer.
    tkft_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Entry storage, compare and shift.
    tkft_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .result (result)
    );

endmodule

>>> hdl/tkft_ctrl.sv
module tkft_ctrl
    import tkft_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    output ctrl_cmd_t cmd
);

`include "top_k_frequency_tracker_assert.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    // Next state and strobe.
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Commands to the datapath.
    assign cmd.load    = start && (state_reg == ST_IDLE);
    assign cmd.compare = (state_reg == ST_COMPARE);
    assign cmd.commit  = (state_reg == ST_COMMIT);
    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;

    `TKFT_ASSERT(a_load_to_compare, cmd.load |=> state_reg == ST_COMPARE)
    `TKFT_ASSERT(a_compare_to_done, cmd.compare |=> cmd.commit ##1 done_reg)
    `TKFT_ASSERT(a_done_when_idle, done_reg |-> state_reg == ST_IDLE && $past(cmd.commit))

endmodule

>>> hdl/tkft_datapath.sv
module tkft_datapath
    import tkft_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctrl_cmd_t cmd,
    input  in_word_t  item,
    output out_word_t result
);

`include "top_k_frequency_tracker_assert.svh"

    // Entry storage in rank order; contents beyond the count are don't care.
    logic [KEY_BITS-1:0]   key_store_reg  [CAPACITY];
    logic [FREQ_W-1:0]     freq_store_reg [CAPACITY];
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] count_inc;

    in_word_t              item_reg;
    logic [CAPACITY-1:0]   match_reg;
    logic [CAPACITY-1:0]   lower_reg;
    out_word_t             result_reg;
    out_word_t             result_next;

    logic [CAPACITY-1:0]   hit;
    logic [COUNT_BITS-1:0] pos;
    logic                  dup;
    logic                  found;
    logic                  full;
    logic                  take;
    logic [KEY_BITS-1:0]   new_key;
    logic [SLOT_BITS-1:0]  slot_idx;
    logic                  slot_ok;

    assign new_key = key_fit(item_reg.key);

    // Capture the word and compare it against every held entry.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.compare)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                match_reg[i] <= (COUNT_BITS'(i) < count_reg) && (key_store_reg[i] == new_key);
                lower_reg[i] <= (COUNT_BITS'(i) < count_reg) &&
                                (freq_store_reg[i] < item_reg.freq);
            end
        end
    end

    // First slot that either repeats the key or ranks lower.
    assign hit   = match_reg | lower_reg;
    assign found = |hit;

    always_comb
    begin
        pos = count_reg;
        dup = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                pos = COUNT_BITS'(i);
                dup = match_reg[i];
            end
        end
    end

    assign full       = (count_reg == COUNT_BITS'(CAPACITY));
    assign take       = (item_reg.cmd == CMD_INSERT) && !dup && (found || !full);
    assign count_inc  = count_reg + COUNT_BITS'(1);
    assign count_next = (take && !full) ? count_inc : count_reg;

    // Insert by moving later entries down one slot; the last one falls off.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && take)
        begin
            if (pos == '0)
            begin
                key_store_reg[0]  <= new_key;
                freq_store_reg[0] <= item_reg.freq;
            end
            for (int j = 1; j < CAPACITY; j++)
            begin
                if (COUNT_BITS'(j) == pos)
                begin
                    key_store_reg[j]  <= new_key;
                    freq_store_reg[j] <= item_reg.freq;
                end
                else if (COUNT_BITS'(j) > pos)
                begin
                    key_store_reg[j]  <= key_store_reg[j-1];
                    freq_store_reg[j] <= freq_store_reg[j-1];
                end
            end
        end
    end

    // Entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
        end
    end

    // Read port and result word.
    assign slot_idx = SLOT_BITS'(item_reg.slot);
    assign slot_ok  = CMP_BITS'(item_reg.slot) < CMP_BITS'(count_reg);

    always_comb
    begin
        result_next             = '0;
        result_next.entry_count = COUNT_W'(count_next);
        if (item_reg.cmd == CMD_READ)
        begin
            if (slot_ok)
            begin
                result_next.read_valid = 1'b1;
                result_next.read_key   = KEY_W'(key_store_reg[slot_idx]);
                result_next.read_freq  = freq_store_reg[slot_idx];
            end
        end
        else
        begin
            result_next.accepted  = take;
            result_next.duplicate = dup;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

    `TKFT_ASSERT_ALWAYS(a_count_bound, count_reg <= COUNT_BITS'(CAPACITY))
    `TKFT_ASSERT(a_count_holds, !cmd.commit |=> $stable(count_reg))
    `TKFT_ASSERT(a_count_grows, cmd.commit && take && !full |=> count_reg == $past(count_inc))

endmodule
